// File: hdl/tdoa_pkg.sv
// ----------------------------------------------------------------------------
// tdoa_pkg
// Types and fixed widths shared by the TDOA direction normaliser.
// ----------------------------------------------------------------------------
package tdoa_pkg;

  localparam int TdoaWidth = 12;
  localparam int DirWidth  = 16;

  typedef struct packed {
    logic signed [TdoaWidth-1:0] tdoa_first;
    logic signed [TdoaWidth-1:0] tdoa_second;
  } tdoa_req_t;

  typedef struct packed {
    logic signed [DirWidth-1:0] dir_x;
    logic signed [DirWidth-1:0] dir_y;
    logic                       direction_valid;
  } tdoa_res_t;

endpackage

// File: hdl/tdoa_direction_normalizer.sv
// ----------------------------------------------------------------------------
// tdoa_direction_normalizer
// Unit direction vector from two microphone time differences.
// ----------------------------------------------------------------------------
// Usage: drive req_i and raise start_i; the pair is taken on any rising edge
// with start_i high and busy_o low. busy_o is always low, so one pair may be
// issued every cycle. The block forms x = 16*(t1-t0), y = 9*(t0+t1), takes
// m = isqrt(x*x+y*y) one root bit per stage, then divides both components by
// m one quotient bit per stage, giving dir = (c << FRAC_BITS) / m in Q1.14.
// A zero vector gives zero components with direction_valid low.
// Results pass through stage A, stage B, the square-root chain, the divider
// chain and the output register, in order. Throughput: one result
// per cycle. Each result is shown on res_o for one cycle with valid_o high.
// The receiver cannot stall; results are not held. Reset clears all stage
// valid bits, so nothing in flight at reset emerges.
// ----------------------------------------------------------------------------
module tdoa_direction_normalizer #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  tdoa_pkg::tdoa_req_t req_i,
  output logic               valid_o,
  output tdoa_pkg::tdoa_res_t res_o
);
  import tdoa_pkg::*;

  localparam int TW  = TdoaWidth;
  localparam int XW  = TW + 5;          // signed x, y
  localparam int MW  = TW + 4;          // magnitudes
  localparam int RW  = MW + 1;          // root width
  localparam int SW  = 2 * RW;          // sum of squares
  localparam int QB  = FRAC_BITS + 1;   // quotient bits
  localparam int QW  = (FRAC_BITS + 2 > DirWidth) ? FRAC_BITS + 2 : DirWidth;
  localparam int Lat = RW + QB + 4;

  assign busy_o = 1'b0;

  // ---- stage A: x, y and magnitudes ----
  logic [TW:0]   diff_w, sum_w;
  logic [XW-1:0] x_w, y_w, sum_ext_w;
  logic [XW-1:0] ax_w, ay_w;

  always_comb begin
    diff_w    = {req_i.tdoa_second[TW-1], req_i.tdoa_second}
              - {req_i.tdoa_first[TW-1], req_i.tdoa_first};
    sum_w     = {req_i.tdoa_second[TW-1], req_i.tdoa_second}
              + {req_i.tdoa_first[TW-1], req_i.tdoa_first};
    x_w       = {diff_w, 4'b0000};
    sum_ext_w = {{(XW-TW-1){sum_w[TW]}}, sum_w};
    y_w       = {sum_ext_w[XW-4:0], 3'b000} + sum_ext_w;
    ax_w      = x_w[XW-1] ? (~x_w + 1'b1) : x_w;
    ay_w      = y_w[XW-1] ? (~y_w + 1'b1) : y_w;
  end

  logic          a_vld_q;
  logic [MW-1:0] a_ax_q, a_ay_q;
  logic          a_sx_q, a_sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    a_ax_q <= ax_w[MW-1:0];
    a_ay_q <= ay_w[MW-1:0];
    a_sx_q <= x_w[XW-1];
    a_sy_q <= y_w[XW-1];
  end

  // ---- stage B: squares ----
  logic            b_vld_q;
  logic [2*MW-1:0] b_xx_q, b_yy_q;
  logic [MW-1:0]   b_ax_q, b_ay_q;
  logic            b_sx_q, b_sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_xx_q <= a_ax_q * a_ax_q;
    b_yy_q <= a_ay_q * a_ay_q;
    b_ax_q <= a_ax_q;
    b_ay_q <= a_ay_q;
    b_sx_q <= a_sx_q;
    b_sy_q <= a_sy_q;
  end

  // ---- square-root chain, one root bit per stage ----
  logic          sq_vld_q  [RW+1];
  logic [SW-1:0] sq_n_q    [RW+1];
  logic [RW+1:0] sq_rem_q  [RW+1];
  logic [RW-1:0] sq_root_q [RW+1];
  logic [MW-1:0] sq_ax_q   [RW+1];
  logic [MW-1:0] sq_ay_q   [RW+1];
  logic          sq_sx_q   [RW+1];
  logic          sq_sy_q   [RW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else begin
      sq_vld_q[0] <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_n_q[0]    <= SW'(b_xx_q) + SW'(b_yy_q);
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
    sq_ax_q[0]   <= b_ax_q;
    sq_ay_q[0]   <= b_ay_q;
    sq_sx_q[0]   <= b_sx_q;
    sq_sy_q[0]   <= b_sy_q;
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [RW+1:0] rem_sh, trial, rem_nx;
    logic          ge;

    always_comb begin
      rem_sh = {sq_rem_q[k][RW-1:0], sq_n_q[k][SW-1 -: 2]};
      trial  = {sq_root_q[k], 2'b01};
      ge     = rem_sh >= trial;
      rem_nx = ge ? rem_sh - trial : rem_sh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k+1] <= 1'b0;
      end else begin
        sq_vld_q[k+1] <= sq_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_n_q[k+1]    <= {sq_n_q[k][SW-3:0], 2'b00};
      sq_rem_q[k+1]  <= rem_nx;
      sq_root_q[k+1] <= {sq_root_q[k][RW-2:0], ge};
      sq_ax_q[k+1]   <= sq_ax_q[k];
      sq_ay_q[k+1]   <= sq_ay_q[k];
      sq_sx_q[k+1]   <= sq_sx_q[k];
      sq_sy_q[k+1]   <= sq_sy_q[k];
    end
  end

  // ---- divider chain, one quotient bit per stage for both components ----
  logic          dv_vld_q [QB];
  logic [RW:0]   dv_rx_q  [QB];
  logic [RW:0]   dv_ry_q  [QB];
  logic [QB-1:0] dv_qx_q  [QB];
  logic [QB-1:0] dv_qy_q  [QB];
  logic [RW-1:0] dv_m_q   [QB];
  logic          dv_sx_q  [QB];
  logic          dv_sy_q  [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic          vld_in;
    logic [RW:0]   rx_in, ry_in;
    logic [QB-1:0] qx_in, qy_in;
    logic [RW-1:0] m_in;
    logic          sx_in, sy_in;
    logic [RW:0]   tx, ty, mx;
    logic          gex, gey;

    if (j == 0) begin : g_first
      assign vld_in = sq_vld_q[RW];
      assign rx_in  = (RW+1)'(sq_ax_q[RW]);
      assign ry_in  = (RW+1)'(sq_ay_q[RW]);
      assign qx_in  = '0;
      assign qy_in  = '0;
      assign m_in   = sq_root_q[RW];
      assign sx_in  = sq_sx_q[RW];
      assign sy_in  = sq_sy_q[RW];
    end else begin : g_next
      assign vld_in = dv_vld_q[j-1];
      assign rx_in  = dv_rx_q[j-1];
      assign ry_in  = dv_ry_q[j-1];
      assign qx_in  = dv_qx_q[j-1];
      assign qy_in  = dv_qy_q[j-1];
      assign m_in   = dv_m_q[j-1];
      assign sx_in  = dv_sx_q[j-1];
      assign sy_in  = dv_sy_q[j-1];
    end

    always_comb begin
      // first step compares the bare magnitude, later ones the doubled remainder
      tx  = (j == 0) ? rx_in : {rx_in[RW-1:0], 1'b0};
      ty  = (j == 0) ? ry_in : {ry_in[RW-1:0], 1'b0};
      mx  = {1'b0, m_in};
      gex = tx >= mx;
      gey = ty >= mx;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j] <= 1'b0;
      end else begin
        dv_vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_rx_q[j] <= gex ? tx - mx : tx;
      dv_ry_q[j] <= gey ? ty - mx : ty;
      dv_qx_q[j] <= {qx_in[QB-2:0], gex};
      dv_qy_q[j] <= {qy_in[QB-2:0], gey};
      dv_m_q[j]  <= m_in;
      dv_sx_q[j] <= sx_in;
      dv_sy_q[j] <= sy_in;
    end
  end

  // ---- output register ----
  logic [QW-1:0] qx_w, qy_w;
  logic          zero_w;
  logic          out_vld_q;
  tdoa_res_t     res_q;

  always_comb begin
    qx_w   = QW'(dv_qx_q[QB-1]);
    qy_w   = QW'(dv_qy_q[QB-1]);
    qx_w   = dv_sx_q[QB-1] ? (~qx_w + 1'b1) : qx_w;
    qy_w   = dv_sy_q[QB-1] ? (~qy_w + 1'b1) : qy_w;
    zero_w = dv_m_q[QB-1] == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dv_vld_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.dir_x           <= zero_w ? '0 : qx_w[DirWidth-1:0];
    res_q.dir_y           <= zero_w ? '0 : qy_w[DirWidth-1:0];
    res_q.direction_valid <= !zero_w;
  end

  assign valid_o = out_vld_q;
  assign res_o   = res_q;

`ifndef SYNTHESIS
  a_lat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Lat valid_o)
    else $error("result missing after pipeline latency");
  a_zero_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.tdoa_first == '0 && req_i.tdoa_second == '0)
      |-> ##Lat (valid_o && !res_o.direction_valid))
    else $error("zero vector not flagged");
  a_zero_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !res_o.direction_valid) |-> (res_o.dir_x == '0 && res_o.dir_y == '0))
    else $error("invalid direction with non-zero components");
  a_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##Lat !valid_o)
    else $error("result without a transfer");
`endif

endmodule
